// File: rtl/irb_pkg.sv
// Shared types and constants for the instruction reuse buffer.
`timescale 1ns / 1ps

package irb_pkg;

    // Fixed field widths of a request and a result.
    localparam int DATA_W         = 64;
    localparam int COUNT_W        = 2;
    localparam int OPERAND_FIELDS = 3;

    // Defaults for the top-level parameters.
    localparam int DEF_ENTRIES      = 16;
    localparam int DEF_MAX_OPERANDS = 3;

    // Request function codes.
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_READ,
        ST_CMP,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the request key and reset the scan
        logic insert;    // write the latched request into the table
        logic read;      // read the entry at the scan slot
        logic advance;   // step the scan to the next younger entry
        logic set_hit;   // record the entry just read as the answer
        logic load_out;  // move the answer into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_insert; // latched request is an insert
        logic empty;     // table holds no entries
        logic match;     // entry read last cycle matches the key
        logic last;      // scan is at the youngest entry
    } t_dp_sts;

endpackage

// File: rtl/instruction_reuse_buffer_core.sv
// Instruction reuse buffer: FIFO-replaced table of results keyed by pc and operands.
// Requests are taken one at a time, only while the controller is idle. A lookup reads
// entries oldest first through a single RAM read port (issued in DISPATCH or READ) and
// compares each in CMP, stopping at the first match, so it examines at most the fill
// level (up to ENTRIES). An insert, or a lookup on an empty table, goes to FINISH.
// Reset: synchronous active-low reset empties the table (fill level and oldest
// pointer go to zero) and clears the output valid; there is no clearing pass.
`timescale 1ns / 1ps

module instruction_reuse_buffer_core #(
    parameter int ENTRIES      = irb_pkg::DEF_ENTRIES,
    parameter int MAX_OPERANDS = irb_pkg::DEF_MAX_OPERANDS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_func,
    input  logic [irb_pkg::DATA_W-1:0]  i_pc,
    input  logic [irb_pkg::COUNT_W-1:0] i_operand_count,
    input  logic [irb_pkg::DATA_W-1:0]  i_operand_a,
    input  logic [irb_pkg::DATA_W-1:0]  i_operand_b,
    input  logic [irb_pkg::DATA_W-1:0]  i_operand_c,
    input  logic [irb_pkg::DATA_W-1:0]  i_new_result,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_hit,
    output logic [irb_pkg::DATA_W-1:0]  o_value
);

    irb_pkg::t_dp_cmd w_cmd;
    irb_pkg::t_dp_sts w_sts;

    // Sequencing of requests and the table scan.
    irb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Table storage, pointers and key compare.
    irb_datapath #(
        .ENTRIES     (ENTRIES),
        .MAX_OPERANDS(MAX_OPERANDS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_func         (i_func),
        .i_pc           (i_pc),
        .i_operand_count(i_operand_count),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .i_operand_c    (i_operand_c),
        .i_new_result   (i_new_result),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_hit          (o_hit),
        .o_value        (o_value)
    );

endmodule

// File: rtl/irb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module irb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/irb_datapath.sv
// Datapath: request key, entry table, FIFO ring pointers, scan and compare.
`timescale 1ns / 1ps

module irb_datapath #(
    parameter int ENTRIES      = irb_pkg::DEF_ENTRIES,
    parameter int MAX_OPERANDS = irb_pkg::DEF_MAX_OPERANDS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_func,
    input  logic [irb_pkg::DATA_W-1:0] i_pc,
    input  logic [irb_pkg::COUNT_W-1:0] i_operand_count,
    input  logic [irb_pkg::DATA_W-1:0] i_operand_a,
    input  logic [irb_pkg::DATA_W-1:0] i_operand_b,
    input  logic [irb_pkg::DATA_W-1:0] i_operand_c,
    input  logic [irb_pkg::DATA_W-1:0] i_new_result,
    input  irb_pkg::t_dp_cmd           i_cmd,
    output irb_pkg::t_dp_sts           o_sts,
    output logic                       o_hit,
    output logic [irb_pkg::DATA_W-1:0] o_value
);

    localparam int DW       = irb_pkg::DATA_W;
    localparam int CW       = irb_pkg::COUNT_W;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = IDX_W + 1;
    localparam int OP_LANES = (MAX_OPERANDS < irb_pkg::OPERAND_FIELDS) ?
                              MAX_OPERANDS : irb_pkg::OPERAND_FIELDS;
    localparam int OPS_W    = OP_LANES * DW;
    localparam int OFS_OPS  = DW;
    localparam int OFS_CNT  = OFS_OPS + OPS_W;
    localparam int OFS_PC   = OFS_CNT + CW;
    localparam int WORD_W   = OFS_PC + DW;

    // Latched request key.
    logic             r_func;
    logic [DW-1:0]    r_pc;
    logic [CW-1:0]    r_cnt;
    logic [OPS_W-1:0] r_ops;
    logic [DW-1:0]    r_new_result;

    // Ring pointers and scan position.
    logic [IDX_W-1:0] r_oldest;
    logic [CNT_W-1:0] r_fill;
    logic [IDX_W-1:0] r_rd_slot;
    logic [CNT_W-1:0] r_left;

    // Answer and output registers.
    logic             r_res_hit;
    logic [DW-1:0]    r_res_value;
    logic             r_out_hit;
    logic [DW-1:0]    r_out_value;

    logic [CW-1:0]    w_cnt;
    logic [OPS_W-1:0] w_ops;
    logic [CNT_W-1:0] w_sum;
    logic [CNT_W-1:0] w_ins_pos;
    logic [IDX_W-1:0] w_ins_slot;
    logic             w_full;
    logic [WORD_W-1:0] w_wr_data;
    logic [WORD_W-1:0] w_rd_data;

    // Next slot around the ring.
    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] x);
        logic [IDX_W-1:0] y;
        if (x == IDX_W'(ENTRIES - 1)) begin
            y = '0;
        end else begin
            y = x + 1'b1;
        end
        return y;
    endfunction

    // Saturate the operand count to the lanes that are kept.
    always_comb begin
        if (i_operand_count > CW'(OP_LANES)) begin
            w_cnt = CW'(OP_LANES);
        end else begin
            w_cnt = i_operand_count;
        end
    end

    // Gather the operand lanes; lanes beyond the count are forced to zero, so
    // stored and compared operand words agree whenever the counts agree.
    always_comb begin
        for (int l = 0; l < OP_LANES; l++) begin
            if (CW'(l) < w_cnt) begin
                case (l)
                    0:       w_ops[l*DW +: DW] = i_operand_a;
                    1:       w_ops[l*DW +: DW] = i_operand_b;
                    default: w_ops[l*DW +: DW] = i_operand_c;
                endcase
            end else begin
                w_ops[l*DW +: DW] = '0;
            end
        end
    end

    // Insert position is the slot just past the youngest entry; when the
    // table is full this lands on the oldest entry, which is then evicted.
    assign w_sum      = {1'b0, r_oldest} + r_fill;
    assign w_ins_pos  = (w_sum >= CNT_W'(ENTRIES)) ? (w_sum - CNT_W'(ENTRIES)) : w_sum;
    assign w_ins_slot = w_ins_pos[IDX_W-1:0];
    assign w_full     = (r_fill == CNT_W'(ENTRIES));
    assign w_wr_data  = {r_pc, r_cnt, r_ops, r_new_result};

    // Key capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func       <= i_func;
            r_pc         <= i_pc;
            r_cnt        <= w_cnt;
            r_ops        <= w_ops;
            r_new_result <= i_new_result;
        end
    end

    // Ring pointers: only inserts move them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_fill   <= '0;
        end else if (i_cmd.insert) begin
            if (w_full) begin
                r_oldest <= wrap_inc(r_oldest);
            end else begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // Scan walks from the oldest entry toward the youngest.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd_slot <= r_oldest;
            r_left    <= r_fill;
        end else if (i_cmd.advance) begin
            r_rd_slot <= wrap_inc(r_rd_slot);
            r_left    <= r_left - 1'b1;
        end
    end

    // Answer held until the output register is free.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_res_hit   <= 1'b0;
            r_res_value <= '0;
        end else if (i_cmd.set_hit) begin
            r_res_hit   <= 1'b1;
            r_res_value <= w_rd_data[DW-1:0];
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_hit   <= r_res_hit;
            r_out_value <= r_res_value;
        end
    end

    // Entry table: one word per slot holds pc, count, operands and result.
    irb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES),
        .ADDR_W(IDX_W)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.insert),
        .i_wr_addr(w_ins_slot),
        .i_wr_data(w_wr_data),
        .i_rd_en  (i_cmd.read),
        .i_rd_addr(r_rd_slot),
        .o_rd_data(w_rd_data)
    );

    // Status toward the controller.
    always_comb begin
        o_sts.is_insert = (r_func == irb_pkg::FUNC_INSERT);
        o_sts.empty     = (r_fill == '0);
        o_sts.last      = (r_left == CNT_W'(1));
        o_sts.match     = (w_rd_data[OFS_PC +: DW] == r_pc)
                       && (w_rd_data[OFS_CNT +: CW] == r_cnt)
                       && (w_rd_data[OFS_OPS +: OPS_W] == r_ops);
    end

    assign o_hit   = r_out_hit;
    assign o_value = r_out_value;

endmodule

// File: rtl/irb_ctrl.sv
// Controller: request handshake, scan sequencing and output register valid.
`timescale 1ns / 1ps

module irb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  irb_pkg::t_dp_sts i_sts,
    output irb_pkg::t_dp_cmd o_cmd
);

    irb_pkg::t_state r_state;
    irb_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;

    // State and output valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= irb_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;

        unique case (r_state)
            irb_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = irb_pkg::ST_DISPATCH;
                end
            end
            irb_pkg::ST_DISPATCH: begin
                if (i_sts.is_insert) begin
                    o_cmd.insert = 1'b1;
                    n_state      = irb_pkg::ST_FINISH;
                end else if (i_sts.empty) begin
                    n_state = irb_pkg::ST_FINISH;
                end else begin
                    o_cmd.read = 1'b1;
                    n_state    = irb_pkg::ST_CMP;
                end
            end
            irb_pkg::ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = irb_pkg::ST_CMP;
            end
            irb_pkg::ST_CMP: begin
                // The first match in oldest-first order wins.
                if (i_sts.match) begin
                    o_cmd.set_hit = 1'b1;
                    n_state       = irb_pkg::ST_FINISH;
                end else if (i_sts.last) begin
                    n_state = irb_pkg::ST_FINISH;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = irb_pkg::ST_READ;
                end
            end
            irb_pkg::ST_FINISH: begin
                // Wait for the output register to be free.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = irb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = irb_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the instruction reuse buffer core.
`timescale 1ns / 1ps

module tb_top;

    localparam int ENTRIES        = irb_pkg::DEF_ENTRIES;
    localparam int MAX_OPERANDS   = irb_pkg::DEF_MAX_OPERANDS;
    localparam int DATA_W         = irb_pkg::DATA_W;
    localparam int COUNT_W        = irb_pkg::COUNT_W;
    localparam int OPERAND_FIELDS = irb_pkg::OPERAND_FIELDS;
    localparam int POOL_DEPTH     = 32;

    // Lookup key of one request: pc, operand count and operand values.
    typedef struct packed {
        logic [DATA_W-1:0]                     pc;
        logic [COUNT_W-1:0]                    count;
        logic [OPERAND_FIELDS-1:0][DATA_W-1:0] ops;
    } t_reuse_key;

    // One response of the block.
    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] value;
    } t_reuse_answer;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_func = irb_pkg::FUNC_LOOKUP;
    logic [DATA_W-1:0]     i_pc = '0;
    logic [COUNT_W-1:0]    i_operand_count = '0;
    logic [DATA_W-1:0]     i_operand_a = '0;
    logic [DATA_W-1:0]     i_operand_b = '0;
    logic [DATA_W-1:0]     i_operand_c = '0;
    logic [DATA_W-1:0]     i_new_result = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_hit;
    logic [DATA_W-1:0]     o_value;

    // Shadow copy of the buffer contents and its FIFO ring.
    logic                                  shadow_valid [ENTRIES];
    logic [DATA_W-1:0]                     shadow_pc    [ENTRIES];
    logic [COUNT_W-1:0]                    shadow_count [ENTRIES];
    logic [OPERAND_FIELDS-1:0][DATA_W-1:0] shadow_ops   [ENTRIES];
    logic [DATA_W-1:0]                     shadow_value [ENTRIES];
    int                                    shadow_oldest = 0;
    int                                    shadow_fill = 0;

    t_reuse_answer pending_answers[$];
    t_reuse_key    recent_keys[$];

    int  fail_count = 0;
    int  hit_count = 0;
    int  miss_count = 0;
    int  insert_count = 0;
    int  evict_count = 0;
    int  answer_count = 0;
    bit  no_idle = 1'b0;
    int  hold_off_left = 0;

    instruction_reuse_buffer_core #(
        .ENTRIES      (ENTRIES),
        .MAX_OPERANDS (MAX_OPERANDS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_pc            (i_pc),
        .i_operand_count (i_operand_count),
        .i_operand_a     (i_operand_a),
        .i_operand_b     (i_operand_b),
        .i_operand_c     (i_operand_c),
        .i_new_result    (i_new_result),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_hit           (o_hit),
        .o_value         (o_value)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Saturate the operand count to what the buffer stores.
    function automatic int clamp_count(input logic [COUNT_W-1:0] raw);
        int c;
        c = raw;
        if (c > MAX_OPERANDS) c = MAX_OPERANDS;
        if (c > OPERAND_FIELDS) c = OPERAND_FIELDS;
        return c;
    endfunction

    // Apply one request to the shadow buffer and return the answer it should give.
    function automatic t_reuse_answer predict_reuse(input logic func, input t_reuse_key key,
                                                    input logic [DATA_W-1:0] result);
        t_reuse_answer ans;
        int            cnt;
        int            slot;
        bit            same;
        ans = '0;
        cnt = clamp_count(key.count);
        if (func == irb_pkg::FUNC_LOOKUP) begin
            // Scan from the oldest entry; the first match answers.
            for (int k = 0; k < shadow_fill; k++) begin
                slot = (shadow_oldest + k) % ENTRIES;
                same = shadow_valid[slot] && shadow_pc[slot] == key.pc
                       && shadow_count[slot] == cnt;
                for (int i = 0; i < cnt; i++)
                    if (shadow_ops[slot][i] != key.ops[i]) same = 1'b0;
                if (same) begin
                    ans.hit = 1'b1;
                    ans.value = shadow_value[slot];
                    break;
                end
            end
            if (ans.hit) hit_count++;
            else miss_count++;
            return ans;
        end
        // Insert: overwrite the oldest entry when full, else append.
        if (shadow_fill >= ENTRIES) begin
            slot = shadow_oldest;
            shadow_oldest = (shadow_oldest + 1) % ENTRIES;
            evict_count++;
        end else begin
            slot = (shadow_oldest + shadow_fill) % ENTRIES;
            shadow_fill++;
        end
        shadow_valid[slot] = 1'b1;
        shadow_pc[slot] = key.pc;
        shadow_count[slot] = COUNT_W'(cnt);
        for (int i = 0; i < OPERAND_FIELDS; i++)
            shadow_ops[slot][i] = (i < cnt) ? key.ops[i] : '0;
        shadow_value[slot] = result;
        insert_count++;
        return ans;
    endfunction

    // Random 64-bit value with the extremes showing up now and then.
    function automatic logic [DATA_W-1:0] rand_word();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r == 2) return DATA_W'($urandom_range(0, 3));
        return {$urandom, $urandom};
    endfunction

    function automatic t_reuse_key fresh_key();
        t_reuse_key key;
        // Half of the keys share a few pcs so that some keys differ only in count or operands.
        if ($urandom_range(0, 1) == 0) key.pc = DATA_W'($urandom_range(0, 7) * 4);
        else key.pc = rand_word();
        key.count = COUNT_W'($urandom_range(0, 3));
        for (int i = 0; i < OPERAND_FIELDS; i++) key.ops[i] = rand_word();
        return key;
    endfunction

    // Operands past the count take no part in a match, so scramble them.
    function automatic t_reuse_key scramble_unused(input t_reuse_key key);
        for (int i = 0; i < OPERAND_FIELDS; i++)
            if (i >= clamp_count(key.count)) key.ops[i] = rand_word();
        return key;
    endfunction

    // A key taken from the recent ones, newer keys more often.
    function automatic t_reuse_key pick_recent();
        int span;
        span = (recent_keys.size() < 24) ? recent_keys.size() : 24;
        return recent_keys[recent_keys.size() - 1 - $urandom_range(0, span - 1)];
    endfunction

    function automatic int sender_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one request, hold it until accepted, and record the predicted answer.
    task automatic send_request(input logic func, input t_reuse_key key,
                                input logic [DATA_W-1:0] result);
        int            gap;
        t_reuse_answer ans;
        gap = sender_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_func = func;
        i_pc = key.pc;
        i_operand_count = key.count;
        i_operand_a = key.ops[0];
        i_operand_b = key.ops[1];
        i_operand_c = key.ops[2];
        i_new_result = result;
        do @(posedge i_clk); while (!o_in_ready);
        ans = predict_reuse(func, key, result);
        pending_answers.insert(pending_answers.size(), ans);
        if (func == irb_pkg::FUNC_INSERT) begin
            recent_keys.insert(recent_keys.size(), key);
            if (recent_keys.size() > POOL_DEPTH) recent_keys.delete(0);
        end
        @(negedge i_clk);
    endtask

    task automatic wait_for_answers();
        i_in_valid = 1'b0;
        while (pending_answers.size() != 0) @(negedge i_clk);
    endtask

    // Result consumer: random stalls, plus a long hold-off on demand.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_left > 0) begin
                i_out_ready = 1'b0;
                hold_off_left--;
            end else if (no_idle) begin
                i_out_ready = 1'b1;
            end else if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 99) < 70) begin
                i_out_ready = 1'b1;
            end else begin
                i_out_ready = 1'b0;
                if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(10, 40);
                else stall_left = $urandom_range(0, 2);
            end
        end
    end

    // Compare every accepted result with the oldest outstanding prediction.
    always @(posedge i_clk) begin
        t_reuse_answer want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            answer_count++;
            if (pending_answers.size() == 0) begin
                $error("result with no request outstanding: hit %0d value %h", o_hit, o_value);
                fail_count++;
            end else begin
                want = pending_answers[0];
                pending_answers.delete(0);
                if (o_hit !== want.hit) begin
                    $error("hit mismatch: expected %0d, actual %0d", want.hit, o_hit);
                    fail_count++;
                end
                if (o_value !== want.value) begin
                    $error("value mismatch: expected %h, actual %h", want.value, o_value);
                    fail_count++;
                end
            end
        end
    end

    // A lookup on an empty buffer must miss.
    task automatic test_empty_lookup();
        t_reuse_key key;
        key.pc = '0;
        key.count = 2'd3;
        key.ops = '1;
        send_request(irb_pkg::FUNC_LOOKUP, key, '1);
    endtask

    // Exact-key matching at the field extremes, including unused operands.
    task automatic test_key_matching();
        t_reuse_key a_key;
        t_reuse_key b_key;
        t_reuse_key probe;
        a_key.pc = '0;
        a_key.count = 2'd0;
        a_key.ops = '0;
        send_request(irb_pkg::FUNC_INSERT, a_key, '1);
        probe = a_key;
        probe.ops = '1;
        send_request(irb_pkg::FUNC_LOOKUP, probe, '0);
        b_key.pc = '1;
        b_key.count = 2'd3;
        b_key.ops = '1;
        send_request(irb_pkg::FUNC_INSERT, b_key, 64'h0123_4567_89ab_cdef);
        send_request(irb_pkg::FUNC_LOOKUP, b_key, '0);
        probe = b_key;
        probe.ops[2] = {1'b0, {(DATA_W-1){1'b1}}};
        send_request(irb_pkg::FUNC_LOOKUP, probe, '0);
        probe = b_key;
        probe.count = 2'd2;
        send_request(irb_pkg::FUNC_LOOKUP, probe, '0);
        probe = b_key;
        probe.pc[0] = 1'b0;
        send_request(irb_pkg::FUNC_LOOKUP, probe, '0);
        // Two operands stored: the third is ignored, the second is compared.
        b_key.pc = 64'h8000_0000_0000_0040;
        b_key.count = 2'd2;
        b_key.ops[0] = 64'haaaa_aaaa_aaaa_aaaa;
        b_key.ops[1] = 64'h5555_5555_5555_5555;
        b_key.ops[2] = '0;
        send_request(irb_pkg::FUNC_INSERT, b_key, 64'h8000_0000_0000_0001);
        probe = b_key;
        probe.ops[2] = '1;
        send_request(irb_pkg::FUNC_LOOKUP, probe, '0);
        probe = b_key;
        probe.ops[1][DATA_W-1] = 1'b1;
        send_request(irb_pkg::FUNC_LOOKUP, probe, '0);
    endtask

    // Duplicate inserts: the older entry keeps answering.
    task automatic test_oldest_match();
        t_reuse_key key;
        key.pc = 64'h0000_0000_0000_1234;
        key.count = 2'd1;
        key.ops = '0;
        key.ops[0] = 64'h5a5a_5a5a_5a5a_5a5a;
        send_request(irb_pkg::FUNC_INSERT, key, 64'h1111);
        send_request(irb_pkg::FUNC_INSERT, key, 64'h2222);
        key.ops[1] = '1;
        key.ops[2] = 64'hdead_beef;
        send_request(irb_pkg::FUNC_LOOKUP, key, '1);
    endtask

    // Overfill the buffer and probe the evicted and surviving keys.
    task automatic test_fifo_eviction();
        t_reuse_key first_key;
        t_reuse_key second_key;
        first_key = fresh_key();
        send_request(irb_pkg::FUNC_INSERT, first_key, rand_word());
        second_key = fresh_key();
        send_request(irb_pkg::FUNC_INSERT, second_key, rand_word());
        for (int n = 0; n < ENTRIES + 2; n++) begin
            send_request(irb_pkg::FUNC_INSERT, fresh_key(), rand_word());
            if (n == ENTRIES - 3) send_request(irb_pkg::FUNC_LOOKUP, first_key, '0);
        end
        send_request(irb_pkg::FUNC_LOOKUP, first_key, '0);
        send_request(irb_pkg::FUNC_LOOKUP, second_key, '0);
        send_request(irb_pkg::FUNC_LOOKUP, recent_keys[recent_keys.size() - 1], '0);
    endtask

    // Mixed traffic: inserts, lookups of recent keys, near misses and fresh-key lookups.
    task automatic test_random_traffic(input int items);
        t_reuse_key key;
        int         r;
        int         which;
        for (int n = 0; n < items; n++) begin
            r = $urandom_range(0, 99);
            if (r < 30 || recent_keys.size() == 0) begin
                send_request(irb_pkg::FUNC_INSERT, fresh_key(), rand_word());
            end else if (r < 40) begin
                send_request(irb_pkg::FUNC_INSERT, scramble_unused(pick_recent()), rand_word());
            end else if (r < 78) begin
                send_request(irb_pkg::FUNC_LOOKUP, scramble_unused(pick_recent()), rand_word());
            end else if (r < 92) begin
                // Near miss: one part of a known key disturbed.
                key = pick_recent();
                which = $urandom_range(0, 2);
                if (which == 0 || key.count == 0) key.pc[$urandom_range(0, DATA_W-1)] ^= 1'b1;
                else if (which == 1) key.count ^= COUNT_W'($urandom_range(1, 3));
                else key.ops[$urandom_range(0, key.count - 1)][$urandom_range(0, DATA_W-1)] ^= 1'b1;
                send_request(irb_pkg::FUNC_LOOKUP, key, rand_word());
            end else begin
                send_request(irb_pkg::FUNC_LOOKUP, fresh_key(), rand_word());
            end
        end
    endtask

    // Hold results back for a long stretch while requests keep coming.
    task automatic test_backpressure();
        hold_off_left = 150;
        test_random_traffic(30);
    endtask

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_pc[i] = '0;
            shadow_count[i] = '0;
            shadow_ops[i] = '0;
            shadow_value[i] = '0;
        end
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_empty_lookup();
        test_key_matching();
        test_oldest_match();
        test_fifo_eviction();
        test_random_traffic(900);
        test_backpressure();
        // Sender pause until the buffer has answered everything.
        wait_for_answers();
        no_idle = 1'b1;
        test_random_traffic(300);
        no_idle = 1'b0;
        test_backpressure();
        test_random_traffic(700);

        wait_for_answers();
        repeat (40) @(negedge i_clk);
        $display("Covered %0d results: %0d lookup hits, %0d lookup misses, %0d inserts.",
                 answer_count, hit_count, miss_count, insert_count);
        $display("FIFO replacement evicted %0d entries; %0d mismatches seen.",
                 evict_count, fail_count);
        if (fail_count == 0 && pending_answers.size() == 0) begin
            $display("PASS instruction_reuse_buffer_core");
        end else begin
            $display("FAIL instruction_reuse_buffer_core");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #4_000_000;
        $display("FAIL instruction_reuse_buffer_core");
        $finish;
    end

endmodule
